>>> rtl/core/pmst_pkg.sv
package pmst_pkg;

   localparam int MAX_NODES   = 64;
   localparam int WEIGHT_BITS = 32;
   localparam int NODE_BITS   = $clog2(MAX_NODES);
   localparam int COUNT_BITS  = $clog2(MAX_NODES + 1);
   localparam int ADDR_BITS   = 2 * NODE_BITS;

   localparam logic [1:0] CSR_NODE_COUNT = 2'd0;

   // Word that walks down the chain of node cells during one scan.
   typedef struct packed {
      logic                   found;
      logic [NODE_BITS-1:0]   pick;
      logic [WEIGHT_BITS-1:0] best;
   } scan_type;

   // Relax command broadcast to all cells for the current column.
   typedef struct packed {
      logic                   valid;
      logic                   clear;
      logic [NODE_BITS-1:0]   pick;
   } relax_type;

endpackage

>>> rtl/core/pmst_cell.sv
// One graph node: best distance, reached, in-tree and parent. It folds its
// own candidate into the scan word from its left neighbor and registers the
// result for its right neighbor, and on a relax command applies the weight
// of its row.
module pmst_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [pmst_pkg::NODE_BITS-1:0]  node_id,
   input  logic                            active,
   input  pmst_pkg::relax_type             relax,
   input  logic [pmst_pkg::WEIGHT_BITS-1:0] relax_weight,
   input  logic                            take,
   input  pmst_pkg::scan_type              scan_prev,
   output pmst_pkg::scan_type              scan_next,
   output logic [pmst_pkg::NODE_BITS-1:0]  parent
);

   logic                            reached_ff, reached_in;
   logic                            tree_ff, tree_in;
   logic [pmst_pkg::WEIGHT_BITS-1:0] dist_ff, dist_in;
   logic [pmst_pkg::NODE_BITS-1:0]  parent_ff, parent_in;
   pmst_pkg::scan_type              scan_ff, scan_in;
   logic                            cand;

   assign cand = active && reached_ff && !tree_ff;

   always_comb begin
      scan_in = scan_prev;
      if (cand && (!scan_prev.found || dist_ff < scan_prev.best)) begin
         scan_in.found = 1'b1;
         scan_in.pick  = node_id;
         scan_in.best  = dist_ff;
      end
   end

   always_comb begin
      reached_in = reached_ff;
      tree_in    = tree_ff;
      dist_in    = dist_ff;
      parent_in  = parent_ff;
      if (relax.clear) begin
         reached_in = (node_id == '0);
         tree_in    = 1'b0;
         dist_in    = '0;
         parent_in  = '0;
      end else begin
         if (take) begin
            tree_in = 1'b1;
         end
         if (relax.valid && active && relax_weight != '0 && !tree_ff && !take &&
             (!reached_ff || relax_weight < dist_ff)) begin
            reached_in = 1'b1;
            dist_in    = relax_weight;
            parent_in  = relax.pick;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reached_ff <= 1'b0;
         tree_ff    <= 1'b0;
      end else begin
         reached_ff <= reached_in;
         tree_ff    <= tree_in;
      end
      dist_ff   <= dist_in;
      parent_ff <= parent_in;
      scan_ff   <= scan_in;
   end

   assign scan_next = scan_ff;
   assign parent    = parent_ff;

endmodule

>>> rtl/core/prim_minimum_spanning_tree.sv
// Channel   | Direction | Handshake            | Word
// req       | in        | start high, busy low | row, col, weight, last flag
// rsp       | out       | rsp_strobe           | child, parent, flags
// csr       | in/out    | APB write/read       | node_count at address 0
//
// A matrix entry is taken when start is high and busy is low. The entry
// with last_entry set starts a run: a clear state, then for each of
// node_count - 1 steps a scan (the scan word ripples one cell per cycle down
// the registered chain) and a relax phase (one registered weight store read
// per node row, then a wait until the last read has been applied). A step
// that finds no candidate skips its relax phase. Results then go out one
// per cycle: node_count - 1 words, or one word for a single node or a
// disconnected graph. Reset is synchronous; the weight store is not
// cleared. The receiver cannot stall, so busy stays high until the final
// word has gone out.
module prim_minimum_spanning_tree (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [5:0]  req_row_index,
   input  logic [5:0]  req_col_index,
   input  logic [31:0] req_edge_weight,
   input  logic        req_last_entry,
   output logic        rsp_strobe,
   output logic [5:0]  rsp_child_node,
   output logic [5:0]  rsp_parent_node,
   output logic        rsp_edge_valid,
   output logic        rsp_connected,
   output logic        rsp_last_result,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [0:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int NB = pmst_pkg::NODE_BITS;
   localparam int CB = pmst_pkg::COUNT_BITS;
   localparam int N  = pmst_pkg::MAX_NODES;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLEAR = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_RELAX = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration: the node count register, saturated at use.
   logic [6:0]    count_ff, count_in;
   logic [CB-1:0] n_eff;

   assign pready = 1'b1;
   assign prdata = {25'd0, count_ff};

   always_comb begin
      count_in = count_ff;
      if (psel && penable && pwrite && paddr == pmst_pkg::CSR_NODE_COUNT[0:0]) begin
         count_in = pwdata[6:0];
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         n_eff = CB'(1);
      end else if (32'(count_ff) > N) begin
         n_eff = CB'(N);
      end else begin
         n_eff = CB'(count_ff);
      end
   end

   // Weight store: written by matrix words, read one entry per node row.
   logic [pmst_pkg::WEIGHT_BITS-1:0] weight_mem [0:N*N-1];
   logic [pmst_pkg::WEIGHT_BITS-1:0] rd_data_ff;
   logic [pmst_pkg::ADDR_BITS-1:0]   rd_addr;
   logic                             accept;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (accept) begin
         weight_mem[{req_row_index, req_col_index}] <= req_edge_weight;
      end
      rd_data_ff <= weight_mem[rd_addr];
   end

   // Sequencing counters. During a scan idx counts the cycles the scan
   // word needs to reach the end of the chain.
   logic [CB-1:0] step_ff, step_in;
   logic [CB-1:0] idx_ff, idx_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [NB-1:0] rd_row_ff, rd_row_in;
   logic [NB-1:0] pick_ff, pick_in;
   logic          conn_ff, conn_in;
   logic          scan_done;
   logic          take;

   pmst_pkg::scan_type  scan_chain [0:N];
   pmst_pkg::relax_type relax;
   logic [NB-1:0]       parents [0:N-1];

   assign rd_addr = {idx_ff[NB-1:0], pick_ff};
   assign scan_chain[0] = '0;
   assign scan_done = (state_ff == ST_SCAN) && (idx_ff == CB'(N));
   assign take = scan_done && scan_chain[N].found;

   always_comb begin
      relax.valid = rd_valid_ff;
      relax.clear = (state_ff == ST_CLEAR);
      relax.pick  = pick_ff;
   end

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         logic                active_g;
         pmst_pkg::relax_type relax_g;
         assign active_g = (CB'(g) < n_eff);
         always_comb begin
            relax_g       = relax;
            relax_g.valid = relax.valid && rd_row_ff == NB'(g);
         end
         pmst_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .node_id      (NB'(g)),
            .active       (active_g),
            .relax        (relax_g),
            .relax_weight (rd_data_ff),
            .take         (take && scan_chain[N].pick == NB'(g)),
            .scan_prev    (scan_chain[g]),
            .scan_next    (scan_chain[g+1]),
            .parent       (parents[g])
         );
      end
   endgenerate

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      idx_in      = idx_ff;
      pick_in     = pick_ff;
      conn_in     = conn_ff;
      rd_valid_in = 1'b0;
      rd_row_in   = idx_ff[NB-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_entry) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            step_in = '0;
            conn_in = 1'b1;
            if (n_eff == CB'(1)) begin
               state_in = ST_EMIT;
               idx_in   = CB'(1);
            end else begin
               state_in = ST_SCAN;
               idx_in   = '0;
            end
         end
         ST_SCAN: begin
            if (!scan_done) begin
               idx_in = idx_ff + CB'(1);
            end else if (scan_chain[N].found) begin
               pick_in  = scan_chain[N].pick;
               idx_in   = '0;
               state_in = ST_RELAX;
            end else begin
               conn_in = 1'b0;
               step_in = step_ff + CB'(1);
               if (step_ff + CB'(2) >= n_eff) begin
                  state_in = ST_EMIT;
                  idx_in   = CB'(1);
               end else begin
                  idx_in = '0;
               end
            end
         end
         ST_RELAX: begin
            if (idx_ff < n_eff) begin
               rd_valid_in = 1'b1;
               idx_in      = idx_ff + CB'(1);
            end else if (!rd_valid_ff) begin
               step_in = step_ff + CB'(1);
               if (step_ff + CB'(2) >= n_eff) begin
                  state_in = ST_EMIT;
                  idx_in   = CB'(1);
               end else begin
                  state_in = ST_SCAN;
                  idx_in   = '0;
               end
            end
         end
         ST_EMIT: begin
            idx_in = idx_ff + CB'(1);
            if (!conn_ff || n_eff == CB'(1) || idx_ff + CB'(1) >= n_eff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= 7'd64;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
      step_ff   <= step_in;
      idx_ff    <= idx_in;
      pick_ff   <= pick_in;
      conn_ff   <= conn_in;
      rd_row_ff <= rd_row_in;
   end

   // Result word, one per emit cycle.
   logic single;
   assign single = !conn_ff || n_eff == CB'(1);

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = (state_ff == ST_EMIT);
   assign rsp_child_node  = single ? '0 : idx_ff[NB-1:0];
   assign rsp_parent_node = single ? '0 : parents[idx_ff[NB-1:0]];
   assign rsp_edge_valid  = !single;
   assign rsp_connected   = conn_ff;
   assign rsp_last_result = single || (idx_ff + CB'(1) >= n_eff);

   a_emit_ends_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_result |=> !rsp_strobe)
      else $error("result after last word");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> busy)
      else $error("scan while idle");
   a_clear_then_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> (state_ff == ST_SCAN || state_ff == ST_EMIT))
      else $error("bad state after clear");
   a_edge_connected: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_edge_valid |-> rsp_connected)
      else $error("edge from disconnected run");

endmodule
